@@ hw/rtl/refraction_ray_endpoint_assert.svh @@
// Assertion macros for the refraction ray endpoint block.
`ifndef REFRACTION_RAY_ENDPOINT_ASSERT_SVH
`define REFRACTION_RAY_ENDPOINT_ASSERT_SVH

// Same-cycle implication on clk, off while rst is high.
`define RRE_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication on clk, off while rst is high.
`define RRE_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hw/rtl/rre_pkg.sv @@
// Shared constants and types for the refraction ray endpoint block.
package rre_pkg;

  localparam int RATIO_W    = 16;
  localparam int FOCAL_W    = 24;
  localparam int POS_W      = 32;
  localparam int NORM_W     = 16;
  localparam int NORM_FRAC  = 14;
  localparam int IN_W       = 3 * POS_W + 3 * NORM_W;
  localparam int OUT_W      = 3 * POS_W;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = FOCAL_W;

  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int REM_W      = ROOT_W + 3;
  localparam int MAG_W      = 30;
  localparam int QUO_W      = MAG_W + 1;
  localparam int DREM_W     = QUO_W + 1;
  localparam int NWORD      = 64;
  localparam int NORM_STEPS = 6;
  localparam int SQRT_LAT   = ROOT_W;
  localparam int DIV_LAT    = QUO_W;

  localparam logic [RATIO_W-1:0] INDEX_RATIO_RST = 16'd4096;
  localparam logic [FOCAL_W-1:0] FOCAL_LEN_RST   = 24'd2621440;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INDEX_RATIO = 8'd0,
    REG_FOCAL_LEN   = 8'd1
  } rre_reg_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0]   pos;
    logic [2:0][NORM_W-1:0]  nrm;
    logic [RATIO_W+NORM_W:0] nc;
    logic                    tir;
  } rre_front_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [2:0]            neg;
    logic                  tir;
    logic                  zero;
  } rre_side_t;

endpackage

@@ hw/rtl/rre_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
module rre_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rre_pkg::RAD_W-1:0]  rad,
  output logic [rre_pkg::ROOT_W-1:0] root
);
  import rre_pkg::*;

  logic [RAD_W-1:0]  x_ch   [0:ROOT_W];
  logic [REM_W-1:0]  rem_ch [0:ROOT_W];
  logic [ROOT_W-1:0] rt_ch  [0:ROOT_W];

  assign x_ch[0]   = rad;
  assign rem_ch[0] = '0;
  assign rt_ch[0]  = '0;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    logic [RAD_W-1:0]  x_q;
    logic [REM_W-1:0]  rem_q;
    logic [REM_W-1:0]  acc;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W-1:0] rt_q;
    logic              fit;

    // bring down the next bit pair, try root*4+1
    assign acc   = {rem_ch[i][REM_W-3:0], x_ch[i][RAD_W-1 -: 2]};
    assign trial = {1'b0, rt_ch[i], 2'b01};
    assign fit   = (acc >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        x_q   <= x_ch[i] << 2;
        rem_q <= fit ? acc - trial : acc;
        rt_q  <= {rt_ch[i][ROOT_W-2:0], fit};
      end
    end

    assign x_ch[i+1]   = x_q;
    assign rem_ch[i+1] = rem_q;
    assign rt_ch[i+1]  = rt_q;
  end

  assign root = rt_ch[ROOT_W];

endmodule

@@ hw/rtl/rre_div.sv @@
// Pipelined restoring divider: (num << MAG_W) / den, one quotient bit per stage.
module rre_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rre_pkg::MAG_W-1:0] num,
  input  logic [rre_pkg::QUO_W-1:0] den,
  output logic [rre_pkg::QUO_W-1:0] quo
);
  import rre_pkg::*;

  logic [DREM_W-1:0] rem_ch [0:QUO_W];
  logic [QUO_W-1:0]  den_ch [0:QUO_W];
  logic [QUO_W-1:0]  q_ch   [0:QUO_W];

  // quotient is below 2^QUO_W, so start from num >> 1
  assign rem_ch[0] = {{(DREM_W-MAG_W+1){1'b0}}, num[MAG_W-1:1]};
  assign den_ch[0] = den;
  assign q_ch[0]   = '0;

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    logic              bit_in;
    logic [DREM_W-1:0] acc;
    logic              fit;
    logic [DREM_W-1:0] rem_q;
    logic [QUO_W-1:0]  den_q;
    logic [QUO_W-1:0]  q_q;

    if (i == 0) begin : g_first
      assign bit_in = num[0];
    end else begin : g_rest
      assign bit_in = 1'b0;
    end

    assign acc = {rem_ch[i][DREM_W-2:0], bit_in};
    assign fit = (acc >= {1'b0, den_ch[i]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q <= fit ? acc - {1'b0, den_ch[i]} : acc;
        den_q <= den_ch[i];
        q_q   <= {q_ch[i][QUO_W-2:0], fit};
      end
    end

    assign rem_ch[i+1] = rem_q;
    assign den_ch[i+1] = den_q;
    assign q_ch[i+1]   = q_q;
  end

  assign quo = q_ch[QUO_W];

endmodule

@@ hw/rtl/refraction_ray_endpoint.sv @@
// Top level: streaming Snell refraction and ray endpoint pipeline.
//
// Usage
//   s_axis: one word per vertex, position (Q16.16) and unit normal (Q2.14).
//   m_axis: one word per vertex, the endpoint position + 1.5*f*ray, saturated,
//           with tuser flagging total internal reflection (endpoint = position).
//   cfg:    register writes (0 = index ratio Q4.12, 1 = focal length Q8.16),
//           always ready; other indices are dropped. Write only while idle.
// Throughput: one word per cycle, with no gaps between words, while m_axis keeps up.
// Depth: 112 register stages. The figure is dominated by the two 32-stage
//   square roots and the 31-stage dividers, each one result bit per stage.
// Reset (rst, synchronous): all stage valid bits clear, registers go to
//   1.0 and 40.0. Payload registers are not reset.
// Stall: when a finished word waits on m_axis, the whole pipeline freezes
//   and s_axis_tready drops; nothing is lost or repeated. While the output
//   register is empty or being taken, a word enters every cycle.
`include "refraction_ray_endpoint_assert.svh"

module refraction_ray_endpoint (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
  input  logic [rre_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // end_x, end_y, end_z
  output logic [rre_pkg::OUT_W-1:0]      m_axis_tdata,
  // total_reflect
  output logic [0:0]                     m_axis_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rre_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rre_pkg::*;

  // stage positions in the valid line
  localparam int ST_B      = 1;
  localparam int ST_ROOT1  = ST_B + SQRT_LAT;
  localparam int ST_C      = ST_ROOT1 + 1;
  localparam int ST_F      = ST_C + 3;
  localparam int ST_G_LAST = ST_F + NORM_STEPS;
  localparam int ST_I      = ST_G_LAST + 2;
  localparam int ST_ROOT2  = ST_I + SQRT_LAT;
  localparam int ST_L      = ST_ROOT2 + DIV_LAT + 3;
  localparam int DEPTH     = ST_L + 1;

  localparam int T_W     = 2 * NORM_W;
  localparam int NN_W    = 2 * RATIO_W;
  localparam int PRB_W   = NN_W + T_W + 1;
  localparam int RADF_W  = PRB_W + 1;
  localparam int NC_W    = RATIO_W + NORM_W + 1;
  localparam int K_W     = ROOT_W + 2;
  localparam int KX_W    = K_W + NORM_W;
  localparam int R_W     = KX_W + 2;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int DIST_W  = FOCAL_W + 2;
  localparam int PROD_W  = QUO_W + DIST_W;
  localparam int RND_SH  = MAG_W + 1;
  localparam int OFF_W   = PROD_W + 1 - RND_SH;
  localparam int ESUM_W  = POS_W + 2;

  localparam logic signed [T_W-1:0]    ONE_C2  = T_W'(1) << (2 * NORM_FRAC);
  localparam logic signed [RADF_W-1:0] RAD_ONE =
    RADF_W'(1) << (2 * (RATIO_W - 4) + 2 * NORM_FRAC);
  localparam logic [PROD_W:0]          RND_HALF = (PROD_W + 1)'(1) << (RND_SH - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [RATIO_W-1:0] index_ratio;
  logic [FOCAL_W-1:0] focal_len;
  logic [DIST_W-1:0]  three_f;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_ratio <= INDEX_RATIO_RST;
      focal_len   <= FOCAL_LEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INDEX_RATIO: begin
          index_ratio <= cfg_data[RATIO_W-1:0];
        end
        REG_FOCAL_LEN: begin
          focal_len <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // 3*f: 1.5*f with the half folded into the final rounding shift
  assign three_f = {2'b00, focal_len} + {1'b0, focal_len, 1'b0};

  // ---------------------------------------------------------------------------
  // Flow control: one enable for every stage, valid bits in a line
  // ---------------------------------------------------------------------------
  logic             en;
  logic [DEPTH-1:0] vld;

  assign en            = !vld[DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: c^2, n^2, n*c
  // ---------------------------------------------------------------------------
  logic signed [NORM_W-1:0] in_c;
  logic signed [T_W-1:0]    a_c2;
  logic signed [T_W-1:0]    a_t;
  logic [NN_W-1:0]          a_nn;
  logic signed [NC_W-1:0]   a_nc;

  logic [2:0][POS_W-1:0]    pos_a;
  logic [2:0][NORM_W-1:0]   nrm_a;
  logic [NN_W-1:0]          nn_a;
  logic signed [T_W-1:0]    t_a;
  logic signed [NC_W-1:0]   nc_a;

  assign in_c = s_axis_tdata[3*POS_W +: NORM_W];
  assign a_c2 = in_c * in_c;
  assign a_t  = ONE_C2 - a_c2;
  assign a_nn = index_ratio * index_ratio;
  assign a_nc = $signed({1'b0, index_ratio}) * in_c;

  always_ff @(posedge clk) begin
    if (en) begin
      pos_a <= s_axis_tdata[3*POS_W-1:0];
      nrm_a <= s_axis_tdata[IN_W-1:3*POS_W];
      nn_a  <= a_nn;
      t_a   <= a_t;
      nc_a  <= a_nc;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: radicand 1 - n^2 (1 - c^2), Q.52; sign gives TIR
  // ---------------------------------------------------------------------------
  logic signed [PRB_W-1:0]  b_prod;
  logic signed [RADF_W-1:0] b_rad;
  logic [RAD_W-1:0]         rad_b;
  rre_front_t               front_b;

  assign b_prod = $signed({1'b0, nn_a}) * t_a;
  assign b_rad  = RAD_ONE - {b_prod[PRB_W-1], b_prod};

  always_ff @(posedge clk) begin
    if (en) begin
      rad_b   <= b_rad[RAD_W-1:0];
      front_b <= '{pos: pos_a, nrm: nrm_a, nc: nc_a, tir: b_rad[RADF_W-1]};
    end
  end

  // square root of the radicand, side data in step alongside
  logic [ROOT_W-1:0] root1;
  rre_front_t        front_dly [0:SQRT_LAT-1];

  rre_sqrt u_sqrt_rad (
    .clk  (clk),
    .en   (en),
    .rad  (rad_b),
    .root (root1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      front_dly[0] <= front_b;
      for (int i = 1; i < SQRT_LAT; i++) begin
        front_dly[i] <= front_dly[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: k = n*c - s
  // ---------------------------------------------------------------------------
  rre_front_t             front_o;
  logic signed [K_W-1:0]  k_c;
  logic [2:0][POS_W-1:0]  pos_c;
  logic [2:0][NORM_W-1:0] nrm_c;
  logic                   tir_c;

  assign front_o = front_dly[SQRT_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      k_c   <= $signed({front_o.nc[NC_W-1], front_o.nc}) - $signed({2'b00, root1});
      pos_c <= front_o.pos;
      nrm_c <= front_o.nrm;
      tir_c <= front_o.tir;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: r = n*d - k*N, Q.40
  // ---------------------------------------------------------------------------
  logic signed [KX_W-1:0] d_kx [3];
  logic signed [R_W-1:0]  d_r  [3];
  logic signed [R_W-1:0]  r_d  [3];
  logic [2:0][POS_W-1:0]  pos_d;
  logic                   tir_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_kx[i] = k_c * $signed(nrm_c[i]);
    end
    d_r[0] = $signed({{(R_W-RATIO_W-2*NORM_FRAC){1'b0}}, index_ratio,
                      {(2*NORM_FRAC){1'b0}}}) - {{2{d_kx[0][KX_W-1]}}, d_kx[0]};
    d_r[1] = -{{2{d_kx[1][KX_W-1]}}, d_kx[1]};
    d_r[2] = -{{2{d_kx[2][KX_W-1]}}, d_kx[2]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_d   <= d_r;
      pos_d <= pos_c;
      tir_d <= tir_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: sign and magnitude
  // ---------------------------------------------------------------------------
  logic [R_W-1:0]        mag_e [3];
  logic [2:0]            neg_e;
  logic [2:0][POS_W-1:0] pos_e;
  logic                  tir_e;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg_e[i] <= r_d[i][R_W-1];
        mag_e[i] <= r_d[i][R_W-1] ? R_W'(-r_d[i]) : R_W'(r_d[i]);
      end
      pos_e <= pos_d;
      tir_e <= tir_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage F: largest magnitude, zero-ray detect
  // ---------------------------------------------------------------------------
  logic [R_W-1:0]        f_m01;
  logic [R_W-1:0]        f_max;
  logic [NWORD-1:0]      max_f;
  logic [2:0][NWORD-1:0] mag_f;
  rre_side_t             side_f;

  assign f_m01 = (mag_e[0] > mag_e[1]) ? mag_e[0] : mag_e[1];
  assign f_max = (f_m01 > mag_e[2]) ? f_m01 : mag_e[2];

  always_ff @(posedge clk) begin
    if (en) begin
      max_f <= {{(NWORD-R_W){1'b0}}, f_max};
      for (int i = 0; i < 3; i++) begin
        mag_f[i] <= {{(NWORD-R_W){1'b0}}, mag_e[i]};
      end
      side_f <= '{pos: pos_e, neg: neg_e, tir: tir_e, zero: (f_max == '0)};
    end
  end

  // ---------------------------------------------------------------------------
  // Stages G: normalise, shifting left by 32,16,..,1 so the top bit lands
  // at bit NWORD-1; the top MAG_W bits of each magnitude, shifted alike,
  // then feed the sum of squares and the dividers
  logic [NWORD-1:0]      g_max_ch  [0:NORM_STEPS];
  logic [2:0][NWORD-1:0] g_mag_ch  [0:NORM_STEPS];
  rre_side_t             g_side_ch [0:NORM_STEPS];

  assign g_max_ch[0]  = max_f;
  assign g_mag_ch[0]  = mag_f;
  assign g_side_ch[0] = side_f;

  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int SH = (NWORD / 2) >> j;
    logic [NWORD-1:0]      max_q;
    logic [2:0][NWORD-1:0] mag_q;
    rre_side_t             side_q;
    logic                  lift;

    assign lift = (g_max_ch[j][NWORD-1 -: SH] == '0);

    always_ff @(posedge clk) begin
      if (en) begin
        max_q <= lift ? g_max_ch[j] << SH : g_max_ch[j];
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= lift ? g_mag_ch[j][i] << SH : g_mag_ch[j][i];
        end
        side_q <= g_side_ch[j];
      end
    end

    assign g_max_ch[j+1]  = max_q;
    assign g_mag_ch[j+1]  = mag_q;
    assign g_side_ch[j+1] = side_q;
  end

  // ---------------------------------------------------------------------------
  // Stages H, I: sum of squares
  // ---------------------------------------------------------------------------
  logic [2:0][MAG_W-1:0] h_n;
  logic [2:0][MAG_W-1:0] h_h;
  logic [SQ_W-1:0]       sq_h [3];
  rre_side_t             side_h;
  logic [2:0][MAG_W-1:0] h_i;
  logic [SUM_W-1:0]      sum_i;
  rre_side_t             side_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_n[i] = g_mag_ch[NORM_STEPS][i][NWORD-1 -: MAG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_h[i] <= h_n[i] * h_n[i];
      end
      h_h    <= h_n;
      side_h <= g_side_ch[NORM_STEPS];
      sum_i  <= {2'b00, sq_h[0]} + {2'b00, sq_h[1]} + {2'b00, sq_h[2]};
      h_i    <= h_h;
      side_i <= side_h;
    end
  end

  // length, then the three quotients
  logic [ROOT_W-1:0]     root2;
  logic [2:0][MAG_W-1:0] h_dly    [0:SQRT_LAT-1];
  rre_side_t             side_dly [0:SQRT_LAT+DIV_LAT-1];
  logic [QUO_W-1:0]      quo      [3];

  rre_sqrt u_sqrt_len (
    .clk  (clk),
    .en   (en),
    .rad  ({{(RAD_W-SUM_W){1'b0}}, sum_i}),
    .root (root2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      h_dly[0]    <= h_i;
      side_dly[0] <= side_i;
      for (int i = 1; i < SQRT_LAT; i++) begin
        h_dly[i] <= h_dly[i-1];
      end
      for (int i = 1; i < SQRT_LAT + DIV_LAT; i++) begin
        side_dly[i] <= side_dly[i-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    rre_div u_div (
      .clk (clk),
      .en  (en),
      .num (h_dly[SQRT_LAT-1][i]),
      .den (root2[QUO_W-1:0]),
      .quo (quo[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Stages J, K, L: scale, round half away, add and saturate
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0]        prod_j [3];
  rre_side_t                side_j;
  logic [PROD_W:0]          k_rnd  [3];
  logic signed [OFF_W:0]    d_k    [3];
  rre_side_t                side_k;
  logic signed [ESUM_W-1:0] l_sum  [3];
  logic [2:0][POS_W-1:0]    l_end;
  logic [2:0][POS_W-1:0]    end_l;
  logic                     refl_l;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k_rnd[i] = {1'b0, prod_j[i]} + RND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_j[i] <= quo[i] * three_f;
        d_k[i]    <= side_j.neg[i] ? -$signed({1'b0, k_rnd[i][PROD_W -: OFF_W]})
                                   :  $signed({1'b0, k_rnd[i][PROD_W -: OFF_W]});
      end
      side_j <= side_dly[SQRT_LAT+DIV_LAT-1];
      side_k <= side_j;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      l_sum[i] = $signed({{2{side_k.pos[i][POS_W-1]}}, side_k.pos[i]})
               + $signed({{(ESUM_W-OFF_W-1){d_k[i][OFF_W]}}, d_k[i]});
      if (side_k.tir || side_k.zero) begin
        l_end[i] = side_k.pos[i];
      end else if (l_sum[i][ESUM_W-1:POS_W-1] == '0 ||
                   l_sum[i][ESUM_W-1:POS_W-1] == '1) begin
        l_end[i] = l_sum[i][POS_W-1:0];
      end else if (l_sum[i][ESUM_W-1]) begin
        l_end[i] = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
        l_end[i] = {1'b0, {(POS_W-1){1'b1}}};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      end_l  <= l_end;
      refl_l <= side_k.tir;
    end
  end

  assign m_axis_tdata = end_l;
  assign m_axis_tuser = refl_l;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `RRE_ASSERT_NXT(a_stall_freezes_mid, !en && vld[ST_C],
                  vld[ST_C] && $stable(k_c), "mid-pipe word moved during a stall")
  `RRE_ASSERT_IMP(a_norm_top_bit, vld[ST_G_LAST] && !g_side_ch[NORM_STEPS].zero,
                  g_max_ch[NORM_STEPS][NWORD-1], "normalised maximum not left-aligned")
  `RRE_ASSERT_IMP(a_len_range,
                  vld[ST_ROOT2] && !side_dly[SQRT_LAT-1].tir && !side_dly[SQRT_LAT-1].zero,
                  !root2[ROOT_W-1] && (root2[ROOT_W-2] || root2[ROOT_W-3]),
                  "ray length outside divider range")

endmodule
